/* hdl/rotation_column_timing_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotation column timing unit
// Concurrent assertion wrappers clocked on clk_i; only RCT_ASSERT obeys rst_ni.
// ----------------------------------------------------------------------------
`ifndef ROTATION_COLUMN_TIMING_UNIT_DEFINES_SVH
`define ROTATION_COLUMN_TIMING_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define RCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rotation column timing assertion failed");

// Checked at every edge, reset included.
`define RCT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("rotation column timing invariant failed");

`endif

/* hdl/rct_pkg.sv */
// ----------------------------------------------------------------------------
// Rotation column timing package
// Shared widths, reset constants, register indexes, state codes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

  localparam int unsigned NowW    = 48;
  localparam int unsigned DurW    = 48;
  localparam int unsigned ColOutW = 8;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] MinTurnRst = 24'd10000;
  localparam logic [CfgW-1:0] FastIntRst = 24'd20000;
  localparam logic [CfgW-1:0] SlowIntRst = 24'd500000;

  // Reset turn period is this many time units per column.
  localparam int unsigned PeriodPerColumn = 355;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_TURN = 2'd0,
    CFG_FAST_INT = 2'd1,
    CFG_SLOW_INT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_COLUMN = 3'b010,
    S_EMIT   = 3'b100
  } ctl_state_e;

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_MOD  = 5'b00010,
    E_DBL  = 5'b00100,
    E_ADD  = 5'b01000,
    E_DONE = 5'b10000
  } eng_state_e;

  typedef struct packed {
    logic               column_changed;
    logic [ColOutW-1:0] column;
    logic [ColOutW-1:0] opposite_column;
    logic               turn_accepted;
    logic [DurW-1:0]    edge_interval;
    logic               fast_event_due;
    logic               slow_event_due;
  } result_t;

endpackage

`default_nettype wire

/* hdl/rct_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one timing request: operation and timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface rct_req_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [rct_pkg::NowW-1:0] now_time;

  modport source (output valid, output operation, output now_time, input ready);
  modport sink   (input valid, input operation, input now_time, output ready);
endinterface

`default_nettype wire

/* hdl/rct_res_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one column and timing result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rct_res_if;
  logic                        valid;
  logic                        ready;
  logic                        column_changed;
  logic [rct_pkg::ColOutW-1:0] column;
  logic [rct_pkg::ColOutW-1:0] opposite_column;
  logic                        turn_accepted;
  logic [rct_pkg::DurW-1:0]    edge_interval;
  logic                        fast_event_due;
  logic                        slow_event_due;

  modport source (
    output valid, output column_changed, output column, output opposite_column,
    output turn_accepted, output edge_interval, output fast_event_due,
    output slow_event_due, input ready
  );
  modport sink (
    input valid, input column_changed, input column, input opposite_column,
    input turn_accepted, input edge_interval, input fast_event_due,
    input slow_event_due, output ready
  );
endinterface

`default_nettype wire

/* hdl/rct_addmod.sv */
// ----------------------------------------------------------------------------
// Modular adder
// Computes (a + b + cin) mod p for a, b below p, with a wrap flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rct_addmod #(
  parameter int unsigned W = 48
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic         cin_i,
  input  wire logic [W-1:0] p_i,
  output logic      [W-1:0] s_o,
  output logic              carry_o
);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum     = {1'b0, a_i} + {1'b0, b_i} + {{W{1'b0}}, cin_i};
  assign diff    = sum - {1'b0, p_i};
  assign carry_o = (sum >= {1'b0, p_i});
  assign s_o     = carry_o ? diff[W-1:0] : sum[W-1:0];

endmodule

`default_nettype wire

/* hdl/rct_column_engine.sv */
// ----------------------------------------------------------------------------
// Column engine
// Sequencer around one modular adder: reduces the elapsed time modulo the
// period bit by bit, then forms floor(r * NUM_COLUMNS / period) by doubling
// and adding over the bits of the column count.
// ----------------------------------------------------------------------------
`default_nettype none

module rct_column_engine #(
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned NUM_COLUMNS = 256,
  localparam int unsigned ColW       = $clog2(NUM_COLUMNS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [TIME_BITS-1:0] elapsed_i,
  input  wire logic [TIME_BITS-1:0] period_i,
  output logic                      done_o,
  output logic      [ColW-1:0]      column_o
);

  localparam int unsigned NBits = $clog2(NUM_COLUMNS + 1);
  localparam int unsigned BiW   = $clog2(NBits);
  localparam int unsigned CntW  = $clog2(TIME_BITS);
  localparam logic [NBits-1:0] NVec   = NBits'(NUM_COLUMNS);
  localparam logic [BiW-1:0]   BiTop  = BiW'(NBits - 1);
  localparam logic [CntW-1:0]  CntTop = CntW'(TIME_BITS - 1);

  rct_pkg::eng_state_e st_q, st_d;

  logic [TIME_BITS-1:0] sh_q;
  logic [TIME_BITS-1:0] rem_q;
  logic [TIME_BITS-1:0] r_q;
  logic [ColW-1:0]      quo_q;
  logic [CntW-1:0]      cnt_q;
  logic [BiW-1:0]       bi_q;

  logic [TIME_BITS-1:0] add_a;
  logic [TIME_BITS-1:0] add_b;
  logic                 add_cin;
  logic [TIME_BITS-1:0] add_s;
  logic                 add_c;

  // During the reduction the next elapsed bit enters as the carry-in.
  always_comb begin
    add_a   = rem_q;
    add_b   = rem_q;
    add_cin = 1'b0;
    case (st_q)
      rct_pkg::E_MOD: begin
        add_cin = sh_q[TIME_BITS-1];
      end
      rct_pkg::E_ADD: begin
        add_b = r_q;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  rct_addmod #(
    .W(TIME_BITS)
  ) u_addmod (
    .a_i    (add_a),
    .b_i    (add_b),
    .cin_i  (add_cin),
    .p_i    (period_i),
    .s_o    (add_s),
    .carry_o(add_c)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      rct_pkg::E_IDLE: begin
        if (start_i) begin
          st_d = (period_i == '0) ? rct_pkg::E_DONE : rct_pkg::E_MOD;
        end
      end
      rct_pkg::E_MOD: begin
        if (cnt_q == '0) begin
          st_d = rct_pkg::E_DBL;
        end
      end
      rct_pkg::E_DBL: begin
        if (NVec[bi_q]) begin
          st_d = rct_pkg::E_ADD;
        end else if (bi_q == '0) begin
          st_d = rct_pkg::E_DONE;
        end
      end
      rct_pkg::E_ADD: begin
        st_d = (bi_q == '0) ? rct_pkg::E_DONE : rct_pkg::E_DBL;
      end
      rct_pkg::E_DONE: begin
        st_d = rct_pkg::E_IDLE;
      end
      default: begin
        st_d = rct_pkg::E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rct_pkg::E_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // The column stays in quo_q after a run until the next start, since the
  // result may wait for a stalled receiver.
  always_ff @(posedge clk_i) begin
    case (st_q)
      rct_pkg::E_IDLE: begin
        if (start_i) begin
          sh_q  <= elapsed_i;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= CntTop;
          bi_q  <= BiTop;
        end
      end
      rct_pkg::E_MOD: begin
        sh_q  <= {sh_q[TIME_BITS-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        rem_q <= add_s;
        if (cnt_q == '0) begin
          r_q   <= add_s;
          rem_q <= '0;
        end
      end
      rct_pkg::E_DBL: begin
        rem_q <= add_s;
        quo_q <= {quo_q[ColW-2:0], add_c};
        if (!NVec[bi_q] && bi_q != '0) begin
          bi_q <= bi_q - 1'b1;
        end
      end
      rct_pkg::E_ADD: begin
        rem_q <= add_s;
        quo_q <= quo_q + ColW'(add_c);
        if (bi_q != '0) begin
          bi_q <= bi_q - 1'b1;
        end
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  assign done_o   = (st_q == rct_pkg::E_DONE);
  assign column_o = quo_q;

endmodule

`default_nettype wire

/* hdl/rotation_column_timing_unit.sv */
// ----------------------------------------------------------------------------
// Rotation column timing unit
// Tracks the rotor angle from hall edges and timestamped time samples.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_i (valid/ready): operation 1 is a hall edge,
//   operation 0 is a time sample; now_time is the timestamp. Each request
//   yields exactly one result on out_o (valid/ready).
//   A hall edge goes straight to the emit state. A time sample first runs
//   the column engine, which does one modular add per cycle: TIME_BITS
//   steps to reduce the elapsed time modulo the period, then one doubling
//   per bit of the column count and one add per set bit.
//   The unit takes one request at a time. A finished result sits in the
//   output register, and in_i is ready again while it waits; a following
//   result is held internally until the receiver takes the previous one.
//   Configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_data_i; the user is to write them only while the unit is idle,
//   which the unit itself does not enforce. Unknown indexes are ignored.
//   Reset clears the turn state to a period of 355 * NUM_COLUMNS and loads
//   the default minimum turn time and deadline intervals.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotation_column_timing_unit_defines.svh"

module rotation_column_timing_unit #(
  parameter int unsigned NUM_COLUMNS = 256,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rct_req_if.sink                           in_i,
  rct_res_if.source                         out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [rct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rct_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned ColW = $clog2(NUM_COLUMNS);
  localparam logic [TIME_BITS-1:0] PeriodRst =
    TIME_BITS'(rct_pkg::PeriodPerColumn * NUM_COLUMNS);
  localparam logic [ColW:0] HalfCols = (ColW + 1)'(NUM_COLUMNS / 2);
  localparam logic [ColW:0] NumCols  = (ColW + 1)'(NUM_COLUMNS);

  rct_pkg::ctl_state_e state_q, state_d;

  logic [rct_pkg::CfgW-1:0] min_turn_q;
  logic [rct_pkg::CfgW-1:0] fast_int_q;
  logic [rct_pkg::CfgW-1:0] slow_int_q;

  logic [TIME_BITS-1:0] last_turn_q;
  logic [TIME_BITS-1:0] period_q;
  logic [ColW-1:0]      prev_col_q;
  logic [TIME_BITS-1:0] last_fast_q;
  logic [TIME_BITS-1:0] last_slow_q;

  logic                 op_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 start_q;

  logic                 out_valid_q;
  rct_pkg::result_t     res_q, res_d;

  logic                 in_accept;
  logic                 emit_go;
  logic                 eng_done;
  logic [ColW-1:0]      eng_col;
  logic [TIME_BITS-1:0] elapsed;

  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS-1:0] fast_gap;
  logic [TIME_BITS-1:0] slow_gap;
  logic                 turn_ok;
  logic                 fast_hit;
  logic                 slow_hit;
  logic [ColW-1:0]      col_sel;
  logic [ColW:0]        opp_sum;
  logic [ColW:0]        opp_col;

  assign in_i.ready = (state_q == rct_pkg::S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign emit_go    = (state_q == rct_pkg::S_EMIT) && (!out_valid_q || out_o.ready);
  assign elapsed    = now_q - last_turn_q;

  rct_column_engine #(
    .TIME_BITS  (TIME_BITS),
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .elapsed_i(elapsed),
    .period_i (period_q),
    .done_o   (eng_done),
    .column_o (eng_col)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      rct_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = in_i.operation ? rct_pkg::S_EMIT : rct_pkg::S_COLUMN;
        end
      end
      rct_pkg::S_COLUMN: begin
        if (eng_done) begin
          state_d = rct_pkg::S_EMIT;
        end
      end
      rct_pkg::S_EMIT: begin
        if (emit_go) begin
          state_d = rct_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rct_pkg::S_IDLE;
      end
    endcase
  end

  // Result of the held request; state is committed when it is emitted.
  always_comb begin
    dur      = now_q - last_turn_q;
    fast_gap = now_q - last_fast_q;
    slow_gap = now_q - last_slow_q;
    turn_ok  = dur > TIME_BITS'(min_turn_q);
    fast_hit = fast_gap > TIME_BITS'(fast_int_q);
    slow_hit = slow_gap > TIME_BITS'(slow_int_q);
    col_sel  = op_q ? prev_col_q : eng_col;
    opp_sum  = {1'b0, col_sel} + HalfCols;
    opp_col  = (opp_sum >= NumCols) ? (opp_sum - NumCols) : opp_sum;

    res_d.column_changed  = !op_q && (eng_col != prev_col_q);
    res_d.column          = rct_pkg::ColOutW'(col_sel);
    res_d.opposite_column = rct_pkg::ColOutW'(opp_col);
    res_d.turn_accepted   = op_q && turn_ok;
    res_d.edge_interval   = op_q ? rct_pkg::DurW'(dur) : '0;
    res_d.fast_event_due  = !op_q && fast_hit;
    res_d.slow_event_due  = !op_q && slow_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rct_pkg::S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      min_turn_q  <= rct_pkg::MinTurnRst;
      fast_int_q  <= rct_pkg::FastIntRst;
      slow_int_q  <= rct_pkg::SlowIntRst;
      last_turn_q <= '0;
      period_q    <= PeriodRst;
      prev_col_q  <= '0;
      last_fast_q <= '0;
      last_slow_q <= '0;
    end else begin
      state_q <= state_d;
      start_q <= in_accept && !in_i.operation;

      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          rct_pkg::CFG_MIN_TURN: min_turn_q <= cfg_data_i;
          rct_pkg::CFG_FAST_INT: fast_int_q <= cfg_data_i;
          rct_pkg::CFG_SLOW_INT: slow_int_q <= cfg_data_i;
          default: begin
            min_turn_q <= min_turn_q;
          end
        endcase
      end

      if (emit_go) begin
        if (op_q) begin
          if (turn_ok) begin
            period_q    <= dur;
            last_turn_q <= now_q;
          end
        end else begin
          prev_col_q <= eng_col;
          if (fast_hit) begin
            last_fast_q <= now_q;
          end
          if (slow_hit) begin
            last_slow_q <= now_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= in_i.operation;
      now_q <= TIME_BITS'(in_i.now_time);
    end
    if (emit_go) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.column_changed  = res_q.column_changed;
  assign out_o.column          = res_q.column;
  assign out_o.opposite_column = res_q.opposite_column;
  assign out_o.turn_accepted   = res_q.turn_accepted;
  assign out_o.edge_interval   = res_q.edge_interval;
  assign out_o.fast_event_due  = res_q.fast_event_due;
  assign out_o.slow_event_due  = res_q.slow_event_due;

  // The engine only finishes while a time sample is waiting for it.
  `RCT_ASSERT(eng_done_in_column, eng_done |-> state_q == rct_pkg::S_COLUMN)
  // An engine run starts in the cycle after a time sample is taken.
  `RCT_ASSERT(start_follows_sample, start_q |-> state_q == rct_pkg::S_COLUMN && !op_q)
  // Accepted periods exceed the minimum, so the period never reaches zero.
  `RCT_ASSERT(period_nonzero, period_q != '0)
  // The stored column always lies inside the ring of columns.
  `RCT_ASSERT(prev_col_in_range, 32'(prev_col_q) < NUM_COLUMNS)

endmodule

`default_nettype wire

/* tb/sv/tb_rotation_column_timing_unit.sv */
// ----------------------------------------------------------------------------
// Rotation column timing unit testbench
// Drives hall edges and time samples into the unit over its valid/ready
// channels and predicts every result in a scoreboard class. A short
// directed sequence covers the boundaries: rejected and accepted turns,
// timestamp wrap, deadline edges and extreme register values. Random
// rotor phases follow, most with random gaps on the channels, the last back to back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotation_column_timing_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        OpSample     = 1'b0;
  localparam logic        OpEdge       = 1'b1;
  localparam logic [rct_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int unsigned ColumnCount  = 256;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 80;

  // Tracks the rotor angle and deadline state and queues one expected
  // result per accepted request.
  class column_tracker_scoreboard;
    logic [rct_pkg::CfgW-1:0]    min_turn;
    logic [rct_pkg::CfgW-1:0]    fast_gap;
    logic [rct_pkg::CfgW-1:0]    slow_gap;
    logic [rct_pkg::NowW-1:0]    turn_start;
    logic [rct_pkg::NowW-1:0]    period;
    logic [rct_pkg::NowW-1:0]    fast_mark;
    logic [rct_pkg::NowW-1:0]    slow_mark;
    logic [rct_pkg::ColOutW-1:0] last_col;
    rct_pkg::result_t            expected_q[$];
    int unsigned        edges, samples, turns, col_moves, fast_hits, slow_hits;
    int unsigned        checked, failures;

    function new();
      min_turn   = rct_pkg::MinTurnRst;
      fast_gap   = rct_pkg::FastIntRst;
      slow_gap   = rct_pkg::SlowIntRst;
      turn_start = '0;
      period     = rct_pkg::NowW'(rct_pkg::PeriodPerColumn * ColumnCount);
      fast_mark  = '0;
      slow_mark  = '0;
      last_col   = '0;
    endfunction

    function void set_register(logic [rct_pkg::CfgIdxW-1:0] idx,
                               logic [rct_pkg::CfgW-1:0] value);
      case (idx)
        rct_pkg::CFG_MIN_TURN: min_turn = value;
        rct_pkg::CFG_FAST_INT: fast_gap = value;
        rct_pkg::CFG_SLOW_INT: slow_gap = value;
        default: ;
      endcase
    endfunction

    function void note_request(logic op, logic [rct_pkg::NowW-1:0] stamp);
      rct_pkg::result_t         want;
      logic [rct_pkg::NowW-1:0] elapsed;
      logic [rct_pkg::NowW-1:0] since;
      logic [63:0]              scaled;
      logic [63:0]              quotient;
      want    = '0;
      elapsed = stamp - turn_start;
      if (op == OpEdge) begin
        edges++;
        want.edge_interval = elapsed;
        if (elapsed > rct_pkg::NowW'(min_turn)) begin
          period     = elapsed;
          turn_start = stamp;
          want.turn_accepted = 1'b1;
          turns++;
        end
        want.column = last_col;
      end else begin
        samples++;
        if (period == '0) begin
          want.column = '0;
        end else begin
          scaled   = {16'd0, elapsed % period} * ColumnCount;
          quotient = scaled / {16'd0, period};
          want.column = quotient[rct_pkg::ColOutW-1:0];
        end
        if (want.column != last_col) begin
          want.column_changed = 1'b1;
          last_col = want.column;
          col_moves++;
        end
        since = stamp - fast_mark;
        if (since > rct_pkg::NowW'(fast_gap)) begin
          want.fast_event_due = 1'b1;
          fast_mark = stamp;
          fast_hits++;
        end
        since = stamp - slow_mark;
        if (since > rct_pkg::NowW'(slow_gap)) begin
          want.slow_event_due = 1'b1;
          slow_mark = stamp;
          slow_hits++;
        end
      end
      want.opposite_column = want.column + rct_pkg::ColOutW'(ColumnCount / 2);
      expected_q.push_back(want);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void check_result(rct_pkg::result_t got);
      rct_pkg::result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result with no request outstanding: col=%0d interval=%0d",
                   $realtime, got.column, got.edge_interval);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch", $realtime);
          $display("  expected chg=%0b col=%0d opp=%0d turn=%0b ivl=%0d fast=%0b slow=%0b",
                   want.column_changed, want.column, want.opposite_column,
                   want.turn_accepted, want.edge_interval,
                   want.fast_event_due, want.slow_event_due);
          $display("  actual   chg=%0b col=%0d opp=%0d turn=%0b ivl=%0d fast=%0b slow=%0b",
                   got.column_changed, got.column, got.opposite_column,
                   got.turn_accepted, got.edge_interval,
                   got.fast_event_due, got.slow_event_due);
        end
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i;
  logic [rct_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [rct_pkg::CfgW-1:0]    cfg_data_i;

  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          quiet;
  int unsigned stuck_cycles;

  column_tracker_scoreboard sb = new();

  rct_req_if req_ch ();
  rct_res_if res_ch ();

  rotation_column_timing_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Both channels and the register port are sampled at the rising edge.
  always @(posedge clk_i) begin : monitor
    rct_pkg::result_t got;
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.column_changed  = res_ch.column_changed;
        got.column          = res_ch.column;
        got.opposite_column = res_ch.opposite_column;
        got.turn_accepted   = res_ch.turn_accepted;
        got.edge_interval   = res_ch.edge_interval;
        got.fast_event_due  = res_ch.fast_event_due;
        got.slow_event_due  = res_ch.slow_event_due;
        sb.check_result(got);
      end
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.operation, req_ch.now_time);
      end
      if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready) || cfg_we_i) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    wait (stuck_cycles >= StallLimit);
    $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
             StallLimit, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Result receiver with random stall bursts.
  initial begin
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && hold == 0 && $urandom_range(1, 100) <= stall_pct) begin
        hold = $urandom_range(1, 8);
      end
      if (hold > 0) begin
        res_ch.ready = 1'b0;
        hold--;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  function automatic logic [rct_pkg::NowW-1:0] rand_stamp();
    logic [63:0] word;
    word = {$urandom(), $urandom()};
    return word[rct_pkg::NowW-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic op, input logic [rct_pkg::NowW-1:0] stamp);
    int unsigned gap;
    if (!quiet && $urandom_range(1, 100) <= idle_pct) begin
      req_ch.valid = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid     = 1'b1;
    req_ch.operation = op;
    req_ch.now_time  = stamp;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_register(input logic [rct_pkg::CfgIdxW-1:0] idx,
                                input logic [rct_pkg::CfgW-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    sb.set_register(idx, value);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [rct_pkg::CfgW-1:0] min_turn,
                           input logic [rct_pkg::CfgW-1:0] fast_gap,
                           input logic [rct_pkg::CfgW-1:0] slow_gap);
    wait_for_results();
    write_register(rct_pkg::CFG_MIN_TURN, min_turn);
    write_register(rct_pkg::CFG_FAST_INT, fast_gap);
    write_register(rct_pkg::CFG_SLOW_INT, slow_gap);
    cfg_we_i = 1'b0;
  endtask

  // Mostly a well-behaved rotor: samples between edges that come about once
  // per turn, with slow speed drift. The rest is glitch edges, repeated
  // samples, long pauses and requests with arbitrary timestamps.
  task automatic run_rotor_phase(input logic [rct_pkg::NowW-1:0] base,
                                 input int unsigned spin);
    logic [rct_pkg::NowW-1:0] clock_now;
    logic [rct_pkg::NowW-1:0] next_turn;
    logic [rct_pkg::NowW-1:0] ahead;
    int unsigned              span;
    int unsigned              pick;
    clock_now = base;
    span      = spin;
    next_turn = base + rct_pkg::NowW'(span);
    repeat (PhaseItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        clock_now = clock_now + rct_pkg::NowW'($urandom_range(1, span / 12 + 1));
        ahead = clock_now - next_turn;
        if (!ahead[rct_pkg::NowW-1]) begin
          clock_now = next_turn;
          send_request(OpEdge, clock_now);
          span = span - span / 16 + $urandom_range(0, span / 8);
          next_turn = clock_now + rct_pkg::NowW'(span);
        end else begin
          send_request(OpSample, clock_now);
        end
      end else if (pick < 80) begin
        clock_now = clock_now + rct_pkg::NowW'($urandom_range(0, 600));
        send_request(OpEdge, clock_now);
      end else if (pick < 86) begin
        send_request($urandom_range(0, 1) == 1 ? OpEdge : OpSample, rand_stamp());
      end else if (pick < 92) begin
        send_request(OpSample, clock_now);
      end else begin
        clock_now = clock_now + rct_pkg::NowW'($urandom_range(span, 4 * span));
        next_turn = clock_now + rct_pkg::NowW'($urandom_range(1, span));
        send_request(OpSample, clock_now);
      end
    end
  endtask

  initial begin
    int unsigned spin;
    req_ch.valid     = 1'b0;
    req_ch.operation = OpSample;
    req_ch.now_time  = '0;
    res_ch.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = rct_pkg::CFG_MIN_TURN;
    cfg_data_i       = '0;
    idle_pct         = 25;
    stall_pct        = 25;
    quiet            = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: column at the start and half a turn, a glitch edge,
    // a real turn, the last column of a turn, both deadlines.
    send_request(OpSample, 48'd0);
    send_request(OpSample, 48'd45440);
    send_request(OpEdge,   48'd5000);
    send_request(OpEdge,   48'd100000);
    send_request(OpSample, 48'd199999);
    send_request(OpSample, 48'd600001);
    // A deadline exactly at its interval does not fire; one unit later it does.
    send_request(OpSample, 48'd620001);
    send_request(OpSample, 48'd620002);
    // Turn intervals at and just above the minimum.
    send_request(OpEdge,   48'd610000);
    send_request(OpEdge,   48'd620000);
    send_request(OpEdge,   48'd620001);
    // Largest timestamp, then timestamps behind the stored ones.
    send_request(OpSample, 48'hFFFF_FFFF_FFFF);
    send_request(OpSample, 48'd3);
    send_request(OpEdge,   48'd7);
    send_request(OpSample, 48'h8000_0000_0000);
    send_request(OpEdge,   48'hFFFF_FFFF_FFFF);

    // A write to the unused index must change nothing.
    wait_for_results();
    write_register(CfgIdxSpare, 24'hFFFFFF);
    cfg_we_i = 1'b0;
    configure(24'd0, 24'd0, 24'd0);
    send_request(OpEdge,   48'hFFFF_FFFF_FFFF);
    send_request(OpEdge,   48'd0);
    send_request(OpSample, 48'd1);
    send_request(OpSample, 48'd1);

    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_request(OpEdge,   48'h00_0000_FFFFFF);
    send_request(OpEdge,   48'h00_0001_000000);
    send_request(OpSample, 48'h00_0001_800000);

    // Random rotor phases with varied settings and gap patterns.
    spin = $urandom_range(60000, 120000);
    configure(rct_pkg::CfgW'($urandom_range(0, spin / 2)),
              rct_pkg::CfgW'($urandom_range(0, 40000)),
              rct_pkg::CfgW'($urandom_range(0, 600000)));
    run_rotor_phase({32'd0, 16'($urandom)}, spin);

    idle_pct  = 0;
    stall_pct = 60;
    spin = $urandom_range(2000, 5000);
    configure(rct_pkg::CfgW'($urandom_range(0, spin / 2)),
              rct_pkg::CfgW'($urandom_range(0, 3000)),
              rct_pkg::CfgW'($urandom_range(0, 40000)));
    run_rotor_phase(rand_stamp(), spin);

    idle_pct  = 40;
    stall_pct = 0;
    spin = $urandom_range(20000, 300000);
    configure(rct_pkg::CfgW'($urandom_range(0, spin / 2)),
              rct_pkg::CfgW'($urandom_range(0, 100000)),
              rct_pkg::CfgW'($urandom_range(0, 2000000)));
    run_rotor_phase(48'hFFFF_FFFF_FFFF - rct_pkg::NowW'($urandom_range(0, 3000000)), spin);

    idle_pct  = 25;
    stall_pct = 25;
    spin = $urandom_range(50000, 400000);
    configure(rct_pkg::CfgW'($urandom_range(0, 24'hFFFFFF)),
              rct_pkg::CfgW'($urandom_range(0, 24'hFFFFFF)),
              rct_pkg::CfgW'($urandom_range(0, 24'hFFFFFF)));
    run_rotor_phase(rand_stamp(), spin);

    idle_pct  = 60;
    stall_pct = 25;
    spin = $urandom_range(5000, 200000);
    configure(rct_pkg::CfgW'($urandom_range(0, spin / 2)),
              rct_pkg::CfgW'($urandom_range(0, 50000)),
              rct_pkg::CfgW'($urandom_range(0, 1000000)));
    run_rotor_phase(rand_stamp(), spin);

    // Back to back at full rate on both channels.
    quiet = 1'b1;
    spin = $urandom_range(10000, 150000);
    configure(rct_pkg::CfgW'($urandom_range(0, spin / 2)),
              rct_pkg::CfgW'($urandom_range(0, 30000)),
              rct_pkg::CfgW'($urandom_range(0, 500000)));
    run_rotor_phase(rand_stamp(), spin);

    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d hall edges (%0d taken as turns) and %0d time samples",
             sb.edges, sb.turns, sb.samples);
    $display("with %0d column changes, %0d fast and %0d slow deadlines; %0d mismatches",
             sb.col_moves, sb.fast_hits, sb.slow_hits, sb.failures);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
